// File: rtl/wspm_pkg.sv
// wspm_pkg: shared constants, request codes and cell control type for the
// wildcard star pattern matcher; no dependencies
package wspm_pkg;

  localparam int unsigned MAX_TOKENS = 16;
  localparam int unsigned IDX_W      = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_TOKENS + 1);
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned CHAR_W     = 8;

  localparam logic [CHAR_W-1:0] CHAR_ANY  = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_STAR = 8'h2A;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_PATTERN = 2'd1,
    REQ_TEXT    = 2'd2,
    REQ_END     = 2'd3
  } req_e;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic              start_pend;
    logic              text_beat;
    logic              tok_write;
    logic              star_mark;
    logic [CHAR_W-1:0] char_val;
    logic [CNT_W-1:0]  tok_count;
  } cell_ctrl_t;

endpackage

// File: rtl/wspm_ifs.sv
// wspm_req_if / wspm_res_if: valid-ready channels for request and result beats
// depends on wspm_pkg
interface wspm_req_if import wspm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [CHAR_W-1:0] char_value;

  modport source (output valid, output req_type, output char_value, input ready);
  modport sink (input valid, input req_type, input char_value, output ready);
endinterface

interface wspm_res_if import wspm_pkg::*; ();
  logic valid;
  logic ready;
  logic matched;
  logic status;

  modport source (output valid, output matched, output status, input ready);
  modport sink (input valid, input matched, input status, output ready);
endinterface

// File: rtl/wspm_cell.sv
// wspm_cell: one pattern token plus the active bit of its position
// depends on wspm_pkg; chained by wildcard_star_pattern_matcher_core through three ripple signals
module wspm_cell import wspm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] idx_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic             start_i,
  input  logic             fwd_i,
  input  logic             clos_i,
  output logic             start_o,
  output logic             fwd_o,
  output logic             clos_o,
  output logic             starred_o,
  output logic             hit_o
);

  logic [CHAR_W-1:0] tok_q;
  logic              star_q;
  logic              act_q, act_d;
  logic              valid, at_end, act_eff, match, take, closed;
  logic              wr_here, star_here;

  assign valid     = CNT_W'(idx_i) < ctrl_i.tok_count;
  assign at_end    = CNT_W'(idx_i) == ctrl_i.tok_count;
  assign wr_here   = ctrl_i.tok_write & at_end;
  assign star_here = ctrl_i.star_mark & (CNT_W'(idx_i) + CNT_W'(1) == ctrl_i.tok_count);

  // a fresh text starts from position 0 closed over leading starred tokens
  assign act_eff = ctrl_i.start_pend ? start_i : act_q;
  assign match   = (tok_q == CHAR_ANY) || (tok_q == ctrl_i.char_val);
  assign take    = valid & act_eff & match;
  assign closed  = fwd_i | (take & star_q) | clos_i;

  assign start_o   = start_i & star_q & valid;
  assign fwd_o     = take & ~star_q;
  assign clos_o    = closed & star_q & valid;
  assign starred_o = star_q;
  assign hit_o     = at_end & act_eff;

  assign act_d = ctrl_i.text_beat ? closed : act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      act_q <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_here) begin
      tok_q  <= ctrl_i.char_val;
      star_q <= 1'b0;
    end else if (star_here) begin
      star_q <= 1'b1;
    end
  end

endmodule

// File: rtl/wildcard_star_pattern_matcher_core.sv
// wildcard_star_pattern_matcher_core: top level, token count, overflow flag,
// cell chain and result register; depends on wspm_pkg, wspm_ifs, wspm_cell
//
// Whole-string matcher for patterns of literal bytes, '.' (any byte) and '*'
// (zero or more of the token before it). Send a clear beat, then pattern
// bytes, then text bytes, then an end beat; only the end beat produces a
// result (matched, status). On each text beat a row of
// MAX_TOKENS cells, one per token, updates the whole active-position vector
// in the cycle the byte arrives, with the star closure rippling from cell to
// cell. A new beat is taken every cycle while the result register is empty
// or being drained. A pattern of more than MAX_TOKENS tokens sets status 1
// and forces matched 0 until the next clear.
module wildcard_star_pattern_matcher_core import wspm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  wspm_req_if.sink   req_i,
  wspm_res_if.source res_o
);

  logic             res_valid_q, res_valid_d;
  logic             matched_q, matched_d;
  logic             status_q, status_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             start_q, start_d;
  logic             act_end_q, act_end_d;

  logic              beat;
  logic              is_clear, is_pat, is_text, is_end;
  logic              last_starred, star_ok, new_tok;
  logic [CNT_W-1:0]  last_cnt;
  cell_ctrl_t        ctrl;

  logic [MAX_TOKENS:0]   start_c, fwd_c, clos_c;
  logic [MAX_TOKENS-1:0] starred, hits;
  logic                  act_end_eff, hit;

  assign req_i.ready = ~res_valid_q | res_o.ready;
  assign beat        = req_i.valid & req_i.ready;
  assign is_clear    = beat & (req_i.req_type == REQ_CLEAR);
  assign is_pat      = beat & (req_i.req_type == REQ_PATTERN);
  assign is_text     = beat & (req_i.req_type == REQ_TEXT);
  assign is_end      = beat & (req_i.req_type == REQ_END);

  // a star marks the last token unless there is none or it is already starred
  assign last_cnt     = count_q - CNT_W'(1);
  assign last_starred = starred[last_cnt[IDX_W-1:0]];
  assign star_ok      = (req_i.char_value == CHAR_STAR) && (count_q != '0) && !last_starred;
  assign new_tok      = is_pat & ~ovf_q & ~star_ok & (count_q < CNT_W'(MAX_TOKENS));

  assign ctrl.start_pend = start_q;
  assign ctrl.text_beat  = is_text;
  assign ctrl.tok_write  = new_tok;
  assign ctrl.star_mark  = is_pat & ~ovf_q & star_ok;
  assign ctrl.char_val   = req_i.char_value;
  assign ctrl.tok_count  = count_q;

  assign start_c[0] = 1'b1;
  assign fwd_c[0]   = 1'b0;
  assign clos_c[0]  = 1'b0;

  for (genvar g = 0; g < MAX_TOKENS; g++) begin : g_cell
    wspm_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .idx_i     (IDX_W'(g)),
      .ctrl_i    (ctrl),
      .start_i   (start_c[g]),
      .fwd_i     (fwd_c[g]),
      .clos_i    (clos_c[g]),
      .start_o   (start_c[g+1]),
      .fwd_o     (fwd_c[g+1]),
      .clos_o    (clos_c[g+1]),
      .starred_o (starred[g]),
      .hit_o     (hits[g])
    );
  end

  // position past the last cell has no token of its own
  assign act_end_eff = start_q ? start_c[MAX_TOKENS] : act_end_q;
  assign act_end_d   = is_text ? (fwd_c[MAX_TOKENS] | clos_c[MAX_TOKENS]) : act_end_q;
  assign hit = (|hits) | (act_end_eff & (count_q == CNT_W'(MAX_TOKENS)));

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    start_d = start_q;
    if (is_clear) begin
      count_d = '0;
      ovf_d   = 1'b0;
      start_d = 1'b1;
    end else if (is_pat) begin
      start_d = 1'b1;
      if (new_tok) begin
        count_d = count_q + CNT_W'(1);
      end else if (!ovf_q && !star_ok) begin
        ovf_d = 1'b1;
      end
    end else if (is_text) begin
      start_d = 1'b0;
    end else if (is_end) begin
      start_d = 1'b1;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q & ~res_o.ready;
    matched_d   = matched_q;
    status_d    = status_q;
    if (is_end) begin
      res_valid_d = 1'b1;
      matched_d   = hit & ~ovf_q;
      status_d    = ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      start_q     <= 1'b1;
      act_end_q   <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      start_q     <= start_d;
      act_end_q   <= act_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    matched_q <= matched_d;
    status_q  <= status_d;
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.matched = matched_q;
  assign res_o.status  = status_q;

endmodule
